/* rtl/isb_pkg.sv */
// Shared constants and command codes for the indexed sequence buffer.
// No dependencies; used by every module of the block.
package isb_pkg;

  // Default number of stored bytes.
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned DATA_W = 8;

  // Command codes carried on the command field.
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

endpackage

/* rtl/isb_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on isb_pkg for default sizes.
module isb_ram #(
  parameter int unsigned Width = isb_pkg::DATA_W,
  parameter int unsigned Depth = isb_pkg::CAPACITY_DEF,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/isb_ctrl.sv */
// Command sequencer: holds the length, walks the RAM to shift, read and search.
// Depends on isb_pkg; drives the ports of one isb_ram instance.
module isb_ctrl #(
  parameter int unsigned Capacity = isb_pkg::CAPACITY_DEF,
  localparam int unsigned AW = $clog2(Capacity),
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command side
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  logic [isb_pkg::CMD_W-1:0] command_i,
  input  logic [CW-1:0]             position_i,
  input  logic [isb_pkg::DATA_W-1:0] value_i,
  // result side
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic                      ok_o,
  output logic [isb_pkg::DATA_W-1:0] read_data_o,
  output logic [AW-1:0]             found_position_o,
  output logic [CW-1:0]             count_o,
  // memory port
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [isb_pkg::DATA_W-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [isb_pkg::DATA_W-1:0] mem_rdata_i
);
  import isb_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHIFT    = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_FIND     = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  localparam logic DIR_INS = 1'b1;
  localparam logic DIR_DEL = 1'b0;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              dir_q, dir_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic              ok_q, ok_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic [AW-1:0]     fpos_q, fpos_d;

  logic [CW-1:0] cnt_m1;
  logic          not_full;

  assign cnt_m1   = count_q - CW'(1);
  assign not_full = (count_q < CW'(Capacity));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dir_d       = dir_q;
    pos_d       = pos_q;
    val_d       = val_q;
    rd_addr_d   = rd_addr_q;
    ok_d        = ok_q;
    rdata_d     = rdata_q;
    fpos_d      = fpos_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pos_d   = position_i;
          val_d   = value_i;
          ok_d    = 1'b0;
          rdata_d = '0;
          fpos_d  = '0;
          state_d = S_DONE;
          case (command_i)
            CMD_APPEND: begin
              if (not_full) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[AW-1:0];
                mem_wdata_o = value_i;
                count_d     = count_q + CW'(1);
                ok_d        = 1'b1;
              end
            end
            CMD_INSERT: begin
              if (not_full && position_i <= count_q) begin
                if (position_i == count_q) begin
                  // insert at the end: plain append
                  mem_we_o    = 1'b1;
                  mem_waddr_o = count_q[AW-1:0];
                  mem_wdata_o = value_i;
                  count_d     = count_q + CW'(1);
                  ok_d        = 1'b1;
                end else begin
                  // open a gap: move entries up, starting at the tail
                  mem_re_o    = 1'b1;
                  mem_raddr_o = cnt_m1[AW-1:0];
                  rd_addr_d   = cnt_m1[AW-1:0];
                  dir_d       = DIR_INS;
                  state_d     = S_SHIFT;
                end
              end
            end
            CMD_DELETE: begin
              if (position_i < count_q) begin
                if (position_i == cnt_m1) begin
                  count_d = cnt_m1;
                  ok_d    = 1'b1;
                end else begin
                  // close the gap: move entries down, starting after it
                  mem_re_o    = 1'b1;
                  mem_raddr_o = AW'(position_i[AW-1:0] + AW'(1));
                  rd_addr_d   = AW'(position_i[AW-1:0] + AW'(1));
                  dir_d       = DIR_DEL;
                  state_d     = S_SHIFT;
                end
              end
            end
            CMD_READ: begin
              if (position_i < count_q) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = position_i[AW-1:0];
                state_d     = S_READ;
              end
            end
            CMD_FIND: begin
              if (count_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                rd_addr_d   = '0;
                state_d     = S_FIND;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
              ok_d    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        if (dir_q == DIR_INS) begin
          mem_waddr_o = AW'(rd_addr_q + AW'(1));
          if (CW'(rd_addr_q) == pos_q) begin
            state_d = S_INS_LAST;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AW'(rd_addr_q - AW'(1));
            rd_addr_d   = AW'(rd_addr_q - AW'(1));
          end
        end else begin
          mem_waddr_o = AW'(rd_addr_q - AW'(1));
          if (CW'(rd_addr_q) == cnt_m1) begin
            count_d = cnt_m1;
            ok_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AW'(rd_addr_q + AW'(1));
            rd_addr_d   = AW'(rd_addr_q + AW'(1));
          end
        end
      end

      S_INS_LAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q[AW-1:0];
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        ok_d        = 1'b1;
        state_d     = S_DONE;
      end

      S_READ: begin
        rdata_d = mem_rdata_i;
        ok_d    = 1'b1;
        state_d = S_DONE;
      end

      S_FIND: begin
        if (mem_rdata_i == val_q) begin
          ok_d    = 1'b1;
          fpos_d  = rd_addr_q;
          state_d = S_DONE;
        end else if (CW'(rd_addr_q) == cnt_m1) begin
          state_d = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(rd_addr_q + AW'(1));
          rd_addr_d   = AW'(rd_addr_q + AW'(1));
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q     <= dir_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    rd_addr_q <= rd_addr_d;
    ok_q      <= ok_d;
    rdata_q   <= rdata_d;
    fpos_q    <= fpos_d;
  end

  assign cmd_ready_o      = (state_q == S_IDLE);
  assign res_valid_o      = (state_q == S_DONE);
  assign ok_o             = ok_q;
  assign read_data_o      = rdata_q;
  assign found_position_o = fpos_q;
  assign count_o          = count_q;

endmodule

/* rtl/indexed_sequence_buffer_unit.sv */
// Indexed sequence buffer: ordered byte sequence in one RAM, edited in place.
// Append, clear and failed commands go straight to the result; read waits for the RAM read;
// insert at p below n shifts entries from the tail down to p, then writes the value; delete
// at p shifts entries above p down; find scans from entry 0 to a match or the last entry.
// One command at a time; shifts and searches move one entry per cycle on the RAM port pair.
// Reset: length cleared to zero, no result pending; RAM contents stay undefined (no sweep).
module indexed_sequence_buffer_unit #(
  parameter int unsigned Capacity = isb_pkg::CAPACITY_DEF,
  localparam int unsigned AW = $clog2(Capacity),
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command beat
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [isb_pkg::CMD_W-1:0]  command_i,
  input  logic [CW-1:0]              position_i,
  input  logic [isb_pkg::DATA_W-1:0] value_i,
  // result beat
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic [isb_pkg::DATA_W-1:0] read_data_o,
  output logic [AW-1:0]              found_position_o,
  output logic [CW-1:0]              length_o,
  output logic                       is_empty_o
);
  import isb_pkg::*;

  // Sequencer <-> RAM
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Sequencer result, held until the output register takes it
  logic              res_valid;
  logic              res_ready;
  logic              res_ok;
  logic [DATA_W-1:0] res_rdata;
  logic [AW-1:0]     res_fpos;
  logic [CW-1:0]     res_count;

  // Output register: parts the sequencer from the consumer, so a finished
  // result can wait here while the next command is already taken.
  logic              out_valid_q, out_valid_d;
  logic              ok_q;
  logic [DATA_W-1:0] rdata_q;
  logic [AW-1:0]     fpos_q;
  logic [CW-1:0]     length_q;
  logic              empty_q;
  logic              load;

  isb_ram #(
    .Width (DATA_W),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  isb_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (in_valid_i),
    .cmd_ready_o      (in_ready_o),
    .command_i        (command_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .ok_o             (res_ok),
    .read_data_o      (res_rdata),
    .found_position_o (res_fpos),
    .count_o          (res_count),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  // Take a new result when the register is empty or is being drained.
  assign res_ready = !out_valid_q || out_ready_i;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      // drop the beat once the consumer took it
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold until the next load.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q     <= res_ok;
      rdata_q  <= res_rdata;
      fpos_q   <= res_fpos;
      length_q <= res_count;
      empty_q  <= (res_count == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = ok_q;
  assign read_data_o      = rdata_q;
  assign found_position_o = fpos_q;
  assign length_o         = length_q;
  assign is_empty_o       = empty_q;

endmodule
